// File: src/rcpfa_pkg.sv
// ----------------------------------------------------------------------------
// rcpfa_pkg
// Shared types and constants of the reference-counted page frame allocator.
// ----------------------------------------------------------------------------
package rcpfa_pkg;

	localparam int ADDR_W     = 32;
	localparam int PCOUNT_W   = 11;
	localparam int STATUS_W   = 3;
	localparam int RCOUNT_W   = 16;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int S_DATA_W   = 32;
	localparam int M_DATA_W   = 56;

	localparam logic [PCOUNT_W-1:0] PAGE_COUNT_RESET = PCOUNT_W'(1024);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_SHARE   = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BADADDR  = 3'd2,
		ST_NOTALLOC = 3'd3,
		ST_SAT      = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_ADDRESS = 1'd0,
		REG_PAGE_COUNT   = 1'd1
	} cfg_reg_t;

endpackage

// File: src/rcpfa_ram.sv
// ----------------------------------------------------------------------------
// rcpfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rcpfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/rcpfa_addr_decode.sv
// ----------------------------------------------------------------------------
// rcpfa_addr_decode
// Turns a byte address into a page index and checks alignment and range.
// ----------------------------------------------------------------------------
module rcpfa_addr_decode #(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_SHIFT = 12
) (
	input  logic [rcpfa_pkg::ADDR_W-1:0]   page_address,
	input  logic [rcpfa_pkg::ADDR_W-1:0]   base_address,
	input  logic [$clog2(MAX_PAGES):0]     pool_size,
	output logic [$clog2(MAX_PAGES)-1:0]   idx,
	output logic                           addr_ok
);

	logic [rcpfa_pkg::ADDR_W-1:0] offset;
	logic [rcpfa_pkg::ADDR_W-1:0] page_num;

	always_comb begin
		offset   = page_address - base_address;
		page_num = offset >> PAGE_SHIFT;
		idx      = page_num[$clog2(MAX_PAGES)-1:0];
		addr_ok  = (offset[PAGE_SHIFT-1:0] == '0) &&
			(page_num < rcpfa_pkg::ADDR_W'(pool_size));
	end

endmodule

// File: src/refcounted_page_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_core
// Page frame allocator with a reference count per page and a free stack.
//
// Channel  Direction  Signals                          Contents
// s_*      in         s_tvalid s_tready s_tuser s_tdata request
// m_*      out        m_tvalid m_tready m_tuser m_tdata result
// cfg_*    in         cfg_valid cfg_ready cfg_index    register write
//                     cfg_data
//
// A request is taken every cycle unless the clearing pass runs or the request
// stage is held; the count memory is read at the transfer, then the request
// stage commits its result to the output register and writes the count back,
// the last write being forwarded to the next request. After reset a clearing
// pass zeroes the count memory with s_tready low; configuration writes are
// always taken. A stalled result holds the request stage, stalling the input.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_core #(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_SHIFT = 12,
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Fields from bit 0: page_address[31:0].
	input  logic [rcpfa_pkg::S_DATA_W-1:0]      s_tdata,
	// Fields from bit 0: operation[1:0].
	input  logic [rcpfa_pkg::OP_W-1:0]          s_tuser,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0: result_address[31:0], reference_count[47:32],
	// page_released[48], zero padding[55:49].
	output logic [rcpfa_pkg::M_DATA_W-1:0]      m_tdata,
	// Fields from bit 0: status[2:0].
	output logic [rcpfa_pkg::STATUS_W-1:0]      m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rcpfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rcpfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IW = $clog2(MAX_PAGES);
	localparam int DW = IW + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [rcpfa_pkg::ADDR_W-1:0]   base_q;
	logic [rcpfa_pkg::PCOUNT_W-1:0] page_count_q;
	logic [DW-1:0]                  pool_size;

	logic          clr_active_q;
	logic [IW-1:0] clr_addr_q;

	logic                       s1_valid_q;
	logic [rcpfa_pkg::OP_W-1:0] op_s1;
	logic [IW-1:0]              idx_s1;
	logic                       addr_ok_s1;

	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_d;
	logic [DW-1:0] wm_q;
	logic [IW-1:0] top_q;

	logic                  fwd_valid_q;
	logic [IW-1:0]         fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	logic                                out_valid_q;
	logic [rcpfa_pkg::STATUS_W-1:0]      out_status_q;
	logic [rcpfa_pkg::ADDR_W-1:0]        out_addr_q;
	logic [rcpfa_pkg::RCOUNT_W-1:0]      out_cnt_q;
	logic                                out_rel_q;

	logic          s_accept;
	logic          commit;
	logic [IW-1:0] dec_idx;
	logic          dec_ok;

	logic [COUNT_BITS-1:0] cnt_rdata;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic [IW-1:0]         stk_rdata;

	rcpfa_pkg::status_t             st;
	logic [rcpfa_pkg::ADDR_W-1:0]   res_addr;
	logic [rcpfa_pkg::RCOUNT_W-1:0] res_cnt;
	logic                           res_rel;
	logic                           cnt_we;
	logic [COUNT_BITS-1:0]          cnt_wdata;
	logic [IW-1:0]                  wr_idx;
	logic                           push;
	logic                           pop;
	logic                           wm_inc;
	logic [COUNT_BITS-1:0]          cnt_inc;
	logic [COUNT_BITS-1:0]          cnt_dec;

	assign cfg_ready = 1'b1;
	assign pool_size = (rcpfa_pkg::ADDR_W'(page_count_q) > rcpfa_pkg::ADDR_W'(MAX_PAGES)) ?
		DW'(MAX_PAGES) : DW'(page_count_q);

	assign commit   = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !clr_active_q && (!s1_valid_q || commit);
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			page_count_q <= rcpfa_pkg::PAGE_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rcpfa_pkg::REG_BASE_ADDRESS: begin
					base_q <= cfg_data;
				end
				rcpfa_pkg::REG_PAGE_COUNT: begin
					page_count_q <= cfg_data[rcpfa_pkg::PCOUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + IW'(1);
			if (clr_addr_q == IW'(MAX_PAGES - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	rcpfa_addr_decode #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_decode (
		.page_address (s_tdata),
		.base_address (base_q),
		.pool_size    (pool_size),
		.idx          (dec_idx),
		.addr_ok      (dec_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_accept) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_s1      <= s_tuser;
			idx_s1     <= dec_idx;
			addr_ok_s1 <= dec_ok;
		end
	end

	rcpfa_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (MAX_PAGES)
	) u_count_ram (
		.clk   (clk),
		.we    (clr_active_q || (commit && cnt_we)),
		.waddr (clr_active_q ? clr_addr_q : wr_idx),
		.wdata (clr_active_q ? '0 : cnt_wdata),
		.re    (s_accept),
		.raddr (dec_idx),
		.rdata (cnt_rdata)
	);

	rcpfa_ram #(
		.WIDTH (IW),
		.DEPTH (MAX_PAGES)
	) u_stack_ram (
		.clk   (clk),
		.we    (commit && push),
		.waddr (depth_q[IW-1:0]),
		.wdata (idx_s1),
		.re    (1'b1),
		.raddr (IW'(depth_d - DW'(2))),
		.rdata (stk_rdata)
	);

	assign cnt_cur = (fwd_valid_q && (fwd_addr_q == idx_s1)) ? fwd_data_q : cnt_rdata;
	assign cnt_inc = cnt_cur + COUNT_BITS'(1);
	assign cnt_dec = cnt_cur - COUNT_BITS'(1);

	always_comb begin
		st        = rcpfa_pkg::ST_OK;
		res_addr  = '0;
		res_cnt   = '0;
		res_rel   = 1'b0;
		cnt_we    = 1'b0;
		cnt_wdata = '0;
		wr_idx    = idx_s1;
		push      = 1'b0;
		pop       = 1'b0;
		wm_inc    = 1'b0;
		case (op_s1)
			rcpfa_pkg::OP_ALLOC: begin
				if (depth_q != '0) begin
					if ({1'b0, top_q} >= pool_size) begin
						st = rcpfa_pkg::ST_EMPTY;
					end else begin
						pop    = 1'b1;
						wr_idx = top_q;
					end
				end else if (wm_q < pool_size) begin
					wm_inc = 1'b1;
					wr_idx = wm_q[IW-1:0];
				end else begin
					st = rcpfa_pkg::ST_EMPTY;
				end
				if (st == rcpfa_pkg::ST_OK) begin
					cnt_we    = 1'b1;
					cnt_wdata = COUNT_BITS'(1);
					res_cnt   = rcpfa_pkg::RCOUNT_W'(1);
					res_addr  = base_q + (rcpfa_pkg::ADDR_W'(wr_idx) << PAGE_SHIFT);
				end
			end
			rcpfa_pkg::OP_SHARE, rcpfa_pkg::OP_RELEASE: begin
				if (!addr_ok_s1) begin
					st = rcpfa_pkg::ST_BADADDR;
				end else if (cnt_cur == '0) begin
					st = rcpfa_pkg::ST_NOTALLOC;
				end else if (op_s1 == rcpfa_pkg::OP_SHARE) begin
					if (cnt_cur == CNT_MAX) begin
						st      = rcpfa_pkg::ST_SAT;
						res_cnt = rcpfa_pkg::RCOUNT_W'(cnt_cur);
					end else begin
						cnt_we    = 1'b1;
						cnt_wdata = cnt_inc;
						res_cnt   = rcpfa_pkg::RCOUNT_W'(cnt_inc);
						res_addr  = base_q + (rcpfa_pkg::ADDR_W'(idx_s1) << PAGE_SHIFT);
					end
				end else begin
					cnt_we    = 1'b1;
					cnt_wdata = cnt_dec;
					res_cnt   = rcpfa_pkg::RCOUNT_W'(cnt_dec);
					res_addr  = base_q + (rcpfa_pkg::ADDR_W'(idx_s1) << PAGE_SHIFT);
					if (cnt_dec == '0) begin
						res_rel = 1'b1;
						push    = (depth_q != DW'(MAX_PAGES));
					end
				end
			end
			default: begin
				st = rcpfa_pkg::ST_BADADDR;
			end
		endcase
	end

	always_comb begin
		depth_d = depth_q;
		if (commit && push) begin
			depth_d = depth_q + DW'(1);
		end else if (commit && pop) begin
			depth_d = depth_q - DW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			wm_q        <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			depth_q <= depth_d;
			if (commit) begin
				fwd_valid_q <= cnt_we;
				if (wm_inc) begin
					wm_q <= wm_q + DW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			fwd_addr_q <= wr_idx;
			fwd_data_q <= cnt_wdata;
			if (push) begin
				top_q <= idx_s1;
			end else if (pop) begin
				top_q <= stk_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q <= st;
			out_addr_q   <= res_addr;
			out_cnt_q    <= res_cnt;
			out_rel_q    <= res_rel;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {7'b0, out_rel_q, out_cnt_q, out_addr_q};

	// No request enters while the count memory is being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !s_tready)
		else $error("request accepted during the clearing pass");

	// The free stack and the fresh watermark never run past MAX_PAGES.
	assert property (@(posedge clk) disable iff (!arst_n)
		(depth_q <= DW'(MAX_PAGES)) && (wm_q <= DW'(MAX_PAGES)))
		else $error("free stack depth or watermark beyond the pool");

	// A request waiting behind a stalled result is kept, not dropped.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !m_tready) |=> s1_valid_q)
		else $error("pending request lost while the output stalled");

	// A page index only joins the free stack when a release frees it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(depth_q > $past(depth_q)) |->
			$past(commit && op_s1 == rcpfa_pkg::OP_RELEASE))
		else $error("free stack grew without a release");

endmodule

// File: verif/rcpfa_checker.sv
// ----------------------------------------------------------------------------
// rcpfa_checker
// Watches the request, result and register channels of the page frame
// allocator, keeps its own copy of the page counts, the free stack and the
// fresh watermark, and compares every result transfer field by field with the
// outcome it worked out for the matching request.
// ----------------------------------------------------------------------------
module rcpfa_checker
	import rcpfa_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [S_DATA_W-1:0]      s_tdata,
	input  logic [OP_W-1:0]          s_tuser,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [M_DATA_W-1:0]      m_tdata,
	input  logic [STATUS_W-1:0]      m_tuser,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output int                       mismatches,
	output int                       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_LIMIT = 1024;
	localparam int PAGE_SHIFT = 12;

	typedef struct {
		status_t              status;
		logic [ADDR_W-1:0]    address;
		logic [RCOUNT_W-1:0]  count;
		logic                 released;
	} page_outcome_t;

	logic [RCOUNT_W-1:0] page_refs [POOL_LIMIT];
	logic [9:0]          free_pages [POOL_LIMIT];
	int                  stack_depth;
	int                  fresh_mark;
	logic [ADDR_W-1:0]   page_base;
	logic [PCOUNT_W-1:0] pool_pages;
	page_outcome_t       awaited_outcomes [$];

	function automatic page_outcome_t serve_request(logic [OP_W-1:0] op,
			logic [ADDR_W-1:0] addr);
		page_outcome_t r;
		int limit;
		int idx;
		logic [ADDR_W-1:0] off;
		r = '{ST_OK, '0, '0, 1'b0};
		limit = (pool_pages > POOL_LIMIT) ? POOL_LIMIT : int'(pool_pages);
		case (op)
			OP_ALLOC: begin
				idx = -1;
				if (stack_depth > 0) begin
					if (int'(free_pages[stack_depth-1]) < limit) begin
						idx = free_pages[stack_depth-1];
						stack_depth--;
					end
				end else if (fresh_mark < limit) begin
					idx = fresh_mark;
					fresh_mark++;
				end
				if (idx < 0) begin
					r.status = ST_EMPTY;
				end else begin
					page_refs[idx] = 1;
					r.address = page_base + (32'(idx) << PAGE_SHIFT);
					r.count = 1;
				end
			end
			OP_SHARE, OP_RELEASE: begin
				off = addr - page_base;
				idx = int'(off >> PAGE_SHIFT);
				if (off[PAGE_SHIFT-1:0] != 0 || idx >= limit) begin
					r.status = ST_BADADDR;
				end else if (page_refs[idx] == 0) begin
					r.status = ST_NOTALLOC;
				end else if (op == OP_SHARE && page_refs[idx] == '1) begin
					r.status = ST_SAT;
					r.count = page_refs[idx];
				end else begin
					if (op == OP_SHARE)
						page_refs[idx] = page_refs[idx] + 1'b1;
					else
						page_refs[idx] = page_refs[idx] - 1'b1;
					r.address = page_base + (32'(idx) << PAGE_SHIFT);
					r.count = page_refs[idx];
					if (op == OP_RELEASE && page_refs[idx] == 0) begin
						r.released = 1'b1;
						free_pages[stack_depth] = 10'(idx);
						stack_depth++;
					end
				end
			end
			default: begin
				r.status = ST_BADADDR;
			end
		endcase
		return r;
	endfunction

	task automatic flag_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		page_outcome_t want;
		if (!arst_n) begin
			for (int k = 0; k < POOL_LIMIT; k++)
				page_refs[k] = '0;
			stack_depth = 0;
			fresh_mark = 0;
			page_base = '0;
			pool_pages = PAGE_COUNT_RESET;
			awaited_outcomes.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BASE_ADDRESS: page_base = cfg_data;
					REG_PAGE_COUNT:   pool_pages = cfg_data[PCOUNT_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (awaited_outcomes.size() == 0) begin
					$display("%0t: result transfer with nothing expected, status 0x%0h data 0x%0h",
						$time, m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = awaited_outcomes.pop_front();
					flag_field("status", 32'(want.status), 32'(m_tuser));
					flag_field("result_address", want.address, m_tdata[31:0]);
					flag_field("reference_count", 32'(want.count), 32'(m_tdata[47:32]));
					flag_field("page_released", 32'(want.released), 32'(m_tdata[48]));
				end
			end
			if (s_tvalid && s_tready)
				awaited_outcomes.push_back(serve_request(s_tuser, s_tdata));
			outstanding = awaited_outcomes.size();
		end
	end

endmodule

// File: verif/refcounted_page_frame_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_core_tb
// Drives the allocator with directed requests covering the pool edges, stale
// free stack entries, bad addresses and the undefined operation, then with
// random request mixes under several pool settings and a short gap-free run
// of shares and releases on one page, while a checker predicts and compares
// every result.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_core_tb;
	import rcpfa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int              WATCHDOG_LIMIT  = 4000;
	localparam int              PRESSURE_CYCLES = 400;
	localparam int              PAGE_BYTES      = 4096;
	localparam logic [OP_W-1:0] OP_UNDEFINED    = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic [S_DATA_W-1:0]     s_tdata;
	logic [OP_W-1:0]         s_tuser;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [M_DATA_W-1:0]     m_tdata;
	logic [STATUS_W-1:0]     m_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	int                      mismatches;
	int                      outstanding;
	int                      quiet_cycles = 0;
	bit                      gaps_on = 1'b1;
	bit                      hold_off = 1'b0;
	logic [ADDR_W-1:0]       base_now;
	logic [PCOUNT_W-1:0]     pages_now;
	logic [ADDR_W-1:0]       last_grant;
	logic [ADDR_W-1:0]       sat_page;

	refcounted_page_frame_allocator_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rcpfa_checker reply_check (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("refcounted_page_frame_allocator_core test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready)
			last_grant <= m_tdata[31:0];

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end else if (gaps_on && $urandom_range(5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_BASE_ADDRESS)
			base_now = value;
		else
			pages_now = value[PCOUNT_W-1:0];
		@(negedge clk);
	endtask

	task automatic push_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
		int gap;
		if (gaps_on && $urandom_range(4) == 0) begin
			gap = $urandom_range(1, 13);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= addr;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_requests(int count, int hold_at);
		int roll;
		int eff;
		int span;
		int idx;
		logic [OP_W-1:0] op;
		logic [ADDR_W-1:0] addr;
		for (int i = 0; i < count; i++) begin
			eff = (pages_now > 1024) ? 1024 : int'(pages_now);
			span = ((eff < 48) ? eff : 48) + 2;
			idx = $urandom_range(span - 1);
			addr = base_now + 32'(idx) * PAGE_BYTES;
			roll = $urandom_range(99);
			if (roll < 30) begin
				op = OP_ALLOC;
				addr = $urandom();
			end else if (roll < 60) begin
				op = OP_SHARE;
			end else if (roll < 88) begin
				op = OP_RELEASE;
			end else begin
				op = 2'($urandom_range(3));
				case ($urandom_range(2))
					0: addr = $urandom();
					1: addr = addr + 32'($urandom_range(1, PAGE_BYTES - 1));
					default: ;
				endcase
			end
			if (i == hold_at)
				hold_off = 1'b1;
			push_request(op, addr);
		end
	endtask

	task automatic run_phase(logic [ADDR_W-1:0] base, logic [CFG_DATA_W-1:0] pages,
			int count, bit gaps, int hold_at);
		settle();
		write_reg(REG_BASE_ADDRESS, base);
		write_reg(REG_PAGE_COUNT, pages);
		gaps_on = gaps;
		random_requests(count, hold_at);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE_ADDRESS;
		cfg_data = '0;
		base_now = '0;
		pages_now = PAGE_COUNT_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_BASE_ADDRESS, 32'hFFFF_F000);
		write_reg(REG_PAGE_COUNT, 32'd4);
		repeat (5) push_request(OP_ALLOC, 32'h0);
		push_request(OP_SHARE, 32'h0000_0000);
		push_request(OP_RELEASE, 32'h0000_0000);
		push_request(OP_RELEASE, 32'h0000_0000);
		push_request(OP_RELEASE, 32'h0000_0000);
		push_request(OP_SHARE, 32'h0000_0000);
		push_request(OP_ALLOC, 32'hFFFF_FFFF);
		push_request(OP_SHARE, 32'h0000_0001);
		push_request(OP_SHARE, 32'h0000_3000);
		push_request(OP_UNDEFINED, 32'hFFFF_FFFF);
		push_request(OP_RELEASE, 32'hFFFF_E000);
		push_request(OP_RELEASE, 32'h0000_2000);
		push_request(OP_SHARE, 32'hFFFF_F000);
		settle();
		write_reg(REG_PAGE_COUNT, 32'd2);
		push_request(OP_ALLOC, 32'h0);
		push_request(OP_SHARE, 32'h0000_2000);
		settle();
		write_reg(REG_PAGE_COUNT, 32'd0);
		push_request(OP_ALLOC, 32'h0);
		push_request(OP_SHARE, 32'hFFFF_F000);
		push_request(OP_RELEASE, 32'h0000_0000);
		settle();
		write_reg(REG_PAGE_COUNT, 32'd4);
		push_request(OP_ALLOC, 32'h0);

		run_phase($urandom() & 32'hFFFF_F000, 32'd8, 300, 1'b1, 100);
		run_phase($urandom(), 32'($urandom_range(1, 32)), 300, 1'b1, -1);
		run_phase(32'h0000_0000, 32'd1024, 300, 1'b0, -1);
		run_phase(32'hFFFF_FFFF, 32'd2047, 300, 1'b1, -1);
		run_phase($urandom() & 32'hFFFF_F000, 32'd1, 300, 1'b1, -1);
		run_phase(32'hFFFF_F000, 32'd16, 350, 1'b1, -1);

		settle();
		gaps_on = 1'b0;
		write_reg(REG_BASE_ADDRESS, 32'h0000_0000);
		write_reg(REG_PAGE_COUNT, 32'd1024);
		push_request(OP_ALLOC, 32'h0);
		settle();
		sat_page = last_grant;
		repeat (12) push_request(OP_SHARE, sat_page);
		push_request(OP_RELEASE, sat_page);
		push_request(OP_SHARE, sat_page);
		push_request(OP_SHARE, sat_page);
		repeat (3) push_request(OP_RELEASE, sat_page);
		settle();
		repeat (8) @(negedge clk);

		if (mismatches == 0)
			$display("refcounted_page_frame_allocator_core test passed");
		else
			$display("refcounted_page_frame_allocator_core test failed");
		$finish;
	end

endmodule
